// ===== hw/rtl/pair_contact_coulomb_force_assert.svh =====
// Assertion macros shared by the pair force RTL.
`ifndef PAIR_CONTACT_COULOMB_FORCE_ASSERT_SVH
`define PAIR_CONTACT_COULOMB_FORCE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PCC_ASSERT_IMP(label, clk, rstn, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pair force assertion failed");

// Next-cycle implication, checked outside reset.
`define PCC_ASSERT_NXT(label, clk, rstn, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pair force assertion failed");

`endif

// ===== hw/rtl/pcc_pkg.sv =====
// Package with widths, register codes and reset values of the pair force block.
package pcc_pkg;
    localparam int POS_W     = 24;
    localparam int RAD_W     = 16;
    localparam int CFG_W     = 16;
    localparam int FORCE_W   = 32;
    localparam int DX_W      = POS_W + 1;
    localparam int RSUM_W    = RAD_W + 1;
    localparam int DIST2_W   = 2 * DX_W;
    localparam int SQRT_RT_W = 32;
    localparam int DIV_NUM_W = 48;
    localparam int CM_W      = DIV_NUM_W;
    localparam int U_W       = 15;
    localparam int OVL_W     = 24;
    localparam int CC_W      = 25;
    localparam int T_W       = 51;
    localparam int PROD_W    = T_W + U_W;
    localparam int P_W       = PROD_W - 14;
    localparam int DIST_SH   = 2 * SQRT_RT_W - DIST2_W;

    localparam logic [CFG_W-1:0] STRENGTH_RESET = 16'd16384;
    localparam logic [CFG_W-1:0] GAIN_RESET     = 16'hF333;

    localparam logic REG_CONTACT_STRENGTH = 1'b0;
    localparam logic REG_COULOMB_GAIN     = 1'b1;
endpackage

// ===== hw/rtl/pcc_isqrt_pipe.sv =====
// Pipelined integer square root, one result bit per stage, with side data.
module pcc_isqrt_pipe import pcc_pkg::*; #(
    parameter int RT_W   = SQRT_RT_W,
    parameter int SIDE_W = 1
) (
    input  logic                aclk,
    input  logic                en,
    input  logic [2*RT_W-1:0]   in_val,
    input  logic [SIDE_W-1:0]   in_side,
    output logic [RT_W-1:0]     out_root,
    output logic [SIDE_W-1:0]   out_side
);
    localparam int REM_W = RT_W + 2;

    logic [REM_W-1:0]  rem_reg  [RT_W];
    logic [RT_W-1:0]   root_reg [RT_W];
    logic [2*RT_W-1:0] val_reg  [RT_W];
    logic [SIDE_W-1:0] side_reg [RT_W];

    for (genvar k = 0; k < RT_W; k++) begin : g_stage
        logic [REM_W-1:0]  rem_in;
        logic [RT_W-1:0]   root_in;
        logic [2*RT_W-1:0] val_in;
        logic [SIDE_W-1:0] side_in;
        logic [REM_W+1:0]  shifted;
        logic [REM_W+1:0]  trial;
        logic              ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign val_in  = in_val;
            assign side_in = in_side;
        end else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign val_in  = val_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        // Bring down the next two radicand bits and try root*4+1.
        always_comb begin
            shifted = {rem_in, val_in[2*RT_W-1 -: 2]};
            trial   = {{(REM_W - RT_W){1'b0}}, root_in, 2'b01};
            ge      = (shifted >= trial);
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= ge ? REM_W'(shifted - trial) : REM_W'(shifted);
                root_reg[k] <= {root_in[RT_W-2:0], ge};
                val_reg[k]  <= {val_in[2*RT_W-3:0], 2'b00};
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_root = root_reg[RT_W-1];
    assign out_side = side_reg[RT_W-1];
endmodule

// ===== hw/rtl/pcc_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage, with side data.
module pcc_div_pipe import pcc_pkg::*; #(
    parameter int NUM_W  = DIV_NUM_W,
    parameter int DEN_W  = SQRT_RT_W,
    parameter int SIDE_W = 1
) (
    input  logic               aclk,
    input  logic               en,
    input  logic [NUM_W-1:0]   in_num,
    input  logic [DEN_W-1:0]   in_den,
    input  logic [SIDE_W-1:0]  in_side,
    output logic [NUM_W-1:0]   out_quo,
    output logic [SIDE_W-1:0]  out_side
);
    logic [DEN_W-1:0]  rem_reg  [NUM_W];
    logic [NUM_W-1:0]  num_reg  [NUM_W];
    logic [DEN_W-1:0]  den_reg  [NUM_W];
    logic [SIDE_W-1:0] side_reg [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [DEN_W-1:0]  rem_in;
        logic [NUM_W-1:0]  num_in;
        logic [DEN_W-1:0]  den_in;
        logic [SIDE_W-1:0] side_in;
        logic [DEN_W:0]    part;
        logic [DEN_W:0]    diff;
        logic              ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign num_in  = in_num;
            assign den_in  = in_den;
            assign side_in = in_side;
        end else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign num_in  = num_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        // The numerator shifts out at the top while quotient bits enter below.
        always_comb begin
            part = {rem_in, num_in[NUM_W-1]};
            diff = part - {1'b0, den_in};
            ge   = (part >= {1'b0, den_in});
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= ge ? diff[DEN_W-1:0] : part[DEN_W-1:0];
                num_reg[k]  <= {num_in[NUM_W-2:0], ge};
                den_reg[k]  <= den_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_quo  = num_reg[NUM_W-1];
    assign out_side = side_reg[NUM_W-1];
endmodule

// ===== hw/rtl/pair_contact_coulomb_force.sv =====
// Top level of the pairwise contact and Coulomb force pipeline.
// Usage: each word on the s_ stream carries one particle pair, two positions
// (signed Q16.8) and two radii (unsigned Q8.8). Each word on the m_ stream
// carries the force on the first particle in signed Q16.16, saturated, with
// near_hit, coincident and saturated flags in m_tuser; the second particle
// takes the negated force. Results leave in input order, one per pair.
// A new pair is accepted every cycle while the receiver does not stall. A
// word passes 90 register stages: four front stages for the input,
// differences, squares and products, 32 square root stages (one root bit
// each), one overlap stage, 48 divider stages (one quotient bit each, three
// dividers side by side) and five back stages for the contact product, sum,
// magnitude, projection and clipping.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_tready falls; nothing is lost or repeated. Synchronous active-low
// reset empties the pipeline and loads contact_strength 0.25 and coulomb_gain
// -0.1. The two registers sit on an APB port at byte addresses 0 and 4; the
// user must write them only while the pipeline is empty, which the block
// itself does not enforce.
`include "pair_contact_coulomb_force_assert.svh"

module pair_contact_coulomb_force import pcc_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    // s_tdata: a_pos_x[23:0], a_pos_y[47:24], a_radius[63:48],
    //          b_pos_x[87:64], b_pos_y[111:88], b_radius[127:112]
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,
    // m_tdata: force_x[31:0], force_y[63:32]
    // m_tuser: near_hit[0], coincident[1], saturated[2]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,
    output logic [2:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    localparam int PIPE_LEN = 4 + SQRT_RT_W + 1 + DIV_NUM_W + 5;
    localparam int UX_PAD   = DIV_NUM_W - DX_W - 21;

    typedef struct packed {
        logic [DX_W-1:0]    adx;
        logic [DX_W-1:0]    ady;
        logic               dxneg;
        logic               dyneg;
        logic [RSUM_W-1:0]  rsum;
        logic               near;
        logic               coin;
        logic [DIST2_W-1:0] dist2;
        logic [CM_W-1:0]    num_cm;
    } sq_side_t;

    typedef struct packed {
        logic [OVL_W-1:0] ovl;
        logic             dxneg;
        logic             dyneg;
    } ux_side_t;

    // Configuration registers.
    logic [CFG_W-1:0] strength_reg;
    logic [CFG_W-1:0] gain_reg;
    logic             cfg_wr;
    logic [CFG_W-1:0] gain_mag;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strength_reg <= STRENGTH_RESET;
            gain_reg     <= GAIN_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_CONTACT_STRENGTH: strength_reg <= pwdata[CFG_W-1:0];
                REG_COULOMB_GAIN:     gain_reg     <= pwdata[CFG_W-1:0];
                default:              ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_CONTACT_STRENGTH: prdata = {16'b0, strength_reg};
            REG_COULOMB_GAIN:     prdata = {16'b0, gain_reg};
            default:              prdata = '0;
        endcase
    end

    // The magnitude of -32768 is 32768, which still fits 16 unsigned bits.
    assign gain_mag = gain_reg[CFG_W-1] ? CFG_W'(~gain_reg + 1'b1) : gain_reg;

    // One enable moves every stage; it drops only when a result waits unread.
    logic                en;
    logic [PIPE_LEN-1:0] valid_reg;

    assign en       = !valid_reg[PIPE_LEN-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = valid_reg[PIPE_LEN-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[PIPE_LEN-2:0], s_tvalid};
        end
    end

    // Stage 0: register the incoming word.
    logic [POS_W-1:0] apx_reg, apy_reg, bpx_reg, bpy_reg;
    logic [RAD_W-1:0] ar_reg, br_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            apx_reg <= s_tdata[23:0];
            apy_reg <= s_tdata[47:24];
            ar_reg  <= s_tdata[63:48];
            bpx_reg <= s_tdata[87:64];
            bpy_reg <= s_tdata[111:88];
            br_reg  <= s_tdata[127:112];
        end
    end

    // Stage 1: separations, their magnitudes and the first radius product.
    logic [DX_W-1:0]   dx_next, dy_next;
    logic [DX_W-1:0]   adx1_reg, ady1_reg;
    logic              dxneg1_reg, dyneg1_reg, coin1_reg;
    logic [RSUM_W-1:0] rsum1_reg;
    logic [RAD_W-1:0]  rb1_reg;
    logic [31:0]       p1_reg;

    assign dx_next = {apx_reg[POS_W-1], apx_reg} - {bpx_reg[POS_W-1], bpx_reg};
    assign dy_next = {apy_reg[POS_W-1], apy_reg} - {bpy_reg[POS_W-1], bpy_reg};

    always_ff @(posedge aclk) begin
        if (en) begin
            adx1_reg   <= dx_next[DX_W-1] ? DX_W'(~dx_next + 1'b1) : dx_next;
            ady1_reg   <= dy_next[DX_W-1] ? DX_W'(~dy_next + 1'b1) : dy_next;
            dxneg1_reg <= dx_next[DX_W-1];
            dyneg1_reg <= dy_next[DX_W-1];
            coin1_reg  <= (dx_next == '0) && (dy_next == '0);
            rsum1_reg  <= {1'b0, ar_reg} + {1'b0, br_reg};
            rb1_reg    <= br_reg;
            p1_reg     <= gain_mag * ar_reg;
        end
    end

    // Stage 2: squares, the full radius product and the box test.
    logic [DIST2_W-1:0] sqx2_reg, sqy2_reg;
    logic [47:0]        p2_reg;
    logic [DX_W-1:0]    adx2_reg, ady2_reg;
    logic               dxneg2_reg, dyneg2_reg, coin2_reg, near2_reg;
    logic [RSUM_W-1:0]  rsum2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sqx2_reg   <= adx1_reg * adx1_reg;
            sqy2_reg   <= ady1_reg * ady1_reg;
            p2_reg     <= p1_reg * rb1_reg;
            near2_reg  <= (adx1_reg <= DX_W'(rsum1_reg)) && (ady1_reg <= DX_W'(rsum1_reg));
            adx2_reg   <= adx1_reg;
            ady2_reg   <= ady1_reg;
            dxneg2_reg <= dxneg1_reg;
            dyneg2_reg <= dyneg1_reg;
            coin2_reg  <= coin1_reg;
            rsum2_reg  <= rsum1_reg;
        end
    end

    // Stage 3: squared distance and the Coulomb numerator |gain|*ra*rb*2.
    sq_side_t sq3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sq3_reg.adx    <= adx2_reg;
            sq3_reg.ady    <= ady2_reg;
            sq3_reg.dxneg  <= dxneg2_reg;
            sq3_reg.dyneg  <= dyneg2_reg;
            sq3_reg.rsum   <= rsum2_reg;
            sq3_reg.near   <= near2_reg;
            sq3_reg.coin   <= coin2_reg;
            sq3_reg.dist2  <= sqx2_reg + sqy2_reg;
            sq3_reg.num_cm <= {p2_reg[CM_W-2:0], 1'b0};
        end
    end

    // Square root of dist2 scaled by 2^14 gives a Q.15 distance.
    logic [SQRT_RT_W-1:0] dist_sq;
    sq_side_t             sq_out;

    pcc_isqrt_pipe #(
        .RT_W   (SQRT_RT_W),
        .SIDE_W ($bits(sq_side_t))
    ) u_isqrt (
        .aclk     (aclk),
        .en       (en),
        .in_val   ({sq3_reg.dist2, {DIST_SH{1'b0}}}),
        .in_side  (sq3_reg),
        .out_root (dist_sq),
        .out_side (sq_out)
    );

    // Overlap stage: contact overlap counts only inside the box and when positive.
    logic [OVL_W-1:0]     rs15;
    logic                 ov_pos;
    logic [SQRT_RT_W-1:0] distx_reg;
    logic [DX_W-1:0]      adxx_reg, adyx_reg;
    logic [DIST2_W-1:0]   dist2x_reg;
    logic [CM_W-1:0]      numcmx_reg;
    ux_side_t             uxs_reg;
    logic                 nearx_reg;
    logic                 coinx_reg;

    assign rs15   = {sq_out.rsum, 7'b0};
    assign ov_pos = sq_out.near && ({8'b0, rs15} > dist_sq);

    always_ff @(posedge aclk) begin
        if (en) begin
            distx_reg     <= dist_sq;
            adxx_reg      <= sq_out.adx;
            adyx_reg      <= sq_out.ady;
            dist2x_reg    <= sq_out.dist2;
            numcmx_reg    <= sq_out.num_cm;
            uxs_reg.ovl   <= ov_pos ? (rs15 - dist_sq[OVL_W-1:0]) : '0;
            uxs_reg.dxneg <= sq_out.dxneg;
            uxs_reg.dyneg <= sq_out.dyneg;
            coinx_reg     <= sq_out.coin;
            nearx_reg     <= sq_out.near;
        end
    end

    // Unit vector components and the Coulomb magnitude, divided side by side.
    logic [DIV_NUM_W-1:0] ux_quo, uy_quo, cm_quo;
    ux_side_t             ux_side;
    logic                 near_div;
    logic                 coin_div;

    pcc_div_pipe #(
        .NUM_W  (DIV_NUM_W),
        .DEN_W  (SQRT_RT_W),
        .SIDE_W ($bits(ux_side_t))
    ) u_div_ux (
        .aclk     (aclk),
        .en       (en),
        .in_num   ({{UX_PAD{1'b0}}, adxx_reg, 21'b0}),
        .in_den   (distx_reg),
        .in_side  (uxs_reg),
        .out_quo  (ux_quo),
        .out_side (ux_side)
    );

    pcc_div_pipe #(
        .NUM_W  (DIV_NUM_W),
        .DEN_W  (SQRT_RT_W),
        .SIDE_W (1)
    ) u_div_uy (
        .aclk     (aclk),
        .en       (en),
        .in_num   ({{UX_PAD{1'b0}}, adyx_reg, 21'b0}),
        .in_den   (distx_reg),
        .in_side  (nearx_reg),
        .out_quo  (uy_quo),
        .out_side (near_div)
    );

    pcc_div_pipe #(
        .NUM_W  (DIV_NUM_W),
        .DEN_W  (DIST2_W),
        .SIDE_W (1)
    ) u_div_cm (
        .aclk     (aclk),
        .en       (en),
        .in_num   (numcmx_reg),
        .in_den   (dist2x_reg),
        .in_side  (coinx_reg),
        .out_quo  (cm_quo),
        .out_side (coin_div)
    );

    // Stage A: contact term strength*overlap in Q.16.
    logic [CFG_W+OVL_W-1:0] ccp;
    logic [CC_W-1:0]        cca_reg;
    logic [CM_W-1:0]        cma_reg;
    logic [U_W-1:0]         uxa_reg, uya_reg;
    logic                   dxnega_reg, dynega_reg, coina_reg, neara_reg;

    assign ccp = strength_reg * ux_side.ovl;

    always_ff @(posedge aclk) begin
        if (en) begin
            cca_reg    <= ccp[CFG_W+OVL_W-1:15];
            cma_reg    <= cm_quo;
            uxa_reg    <= ux_quo[U_W-1:0];
            uya_reg    <= uy_quo[U_W-1:0];
            dxnega_reg <= ux_side.dxneg;
            dynega_reg <= ux_side.dyneg;
            coina_reg  <= coin_div;
            neara_reg  <= near_div;
        end
    end

    // Stage B: signed sum of the two terms along the separation.
    logic [T_W-1:0] cc_ext, cm_ext;
    logic [T_W-1:0] tb_reg;
    logic [U_W-1:0] uxb_reg, uyb_reg;
    logic           dxnegb_reg, dynegb_reg, coinb_reg, nearb_reg;

    assign cc_ext = {{(T_W - CC_W){1'b0}}, cca_reg};
    assign cm_ext = {{(T_W - CM_W){1'b0}}, cma_reg};

    always_ff @(posedge aclk) begin
        if (en) begin
            tb_reg     <= gain_reg[CFG_W-1] ? (cc_ext - cm_ext) : (cc_ext + cm_ext);
            uxb_reg    <= uxa_reg;
            uyb_reg    <= uya_reg;
            dxnegb_reg <= dxnega_reg;
            dynegb_reg <= dynega_reg;
            coinb_reg  <= coina_reg;
            nearb_reg  <= neara_reg;
        end
    end

    // Stage C: magnitude and sign of the sum.
    logic [T_W-1:0] tmc_reg;
    logic           tnegc_reg;
    logic [U_W-1:0] uxc_reg, uyc_reg;
    logic           dxnegc_reg, dynegc_reg, coinc_reg, nearc_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            tmc_reg    <= tb_reg[T_W-1] ? T_W'(~tb_reg + 1'b1) : tb_reg;
            tnegc_reg  <= tb_reg[T_W-1];
            uxc_reg    <= uxb_reg;
            uyc_reg    <= uyb_reg;
            dxnegc_reg <= dxnegb_reg;
            dynegc_reg <= dynegb_reg;
            coinc_reg  <= coinb_reg;
            nearc_reg  <= nearb_reg;
        end
    end

    // Stage D: project the magnitude onto each unit component.
    logic [PROD_W-1:0] pxd_reg, pyd_reg;
    logic              negxd_reg, negyd_reg, coind_reg, neard_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            pxd_reg   <= tmc_reg * uxc_reg;
            pyd_reg   <= tmc_reg * uyc_reg;
            negxd_reg <= tnegc_reg ^ dxnegc_reg;
            negyd_reg <= tnegc_reg ^ dynegc_reg;
            coind_reg <= coinc_reg;
            neard_reg <= nearc_reg;
        end
    end

    // Stage E: drop 14 fraction bits, clip each component, register the result.
    logic [P_W-1:0]     px, py;
    logic [FORCE_W-1:0] fx_c, fy_c;
    logic               satx_c, saty_c;
    logic [FORCE_W-1:0] fx_reg, fy_reg;
    logic               near_reg, coin_reg, sat_reg;

    assign px = pxd_reg[PROD_W-1:14];
    assign py = pyd_reg[PROD_W-1:14];

    always_comb begin
        satx_c = 1'b0;
        saty_c = 1'b0;
        if (negxd_reg) begin
            if (px > P_W'(64'd2147483648)) begin
                satx_c = 1'b1;
                fx_c   = 32'h8000_0000;
            end else begin
                fx_c = FORCE_W'(~px + 1'b1);
            end
        end else begin
            if (px > P_W'(64'd2147483647)) begin
                satx_c = 1'b1;
                fx_c   = 32'h7FFF_FFFF;
            end else begin
                fx_c = px[FORCE_W-1:0];
            end
        end
        if (negyd_reg) begin
            if (py > P_W'(64'd2147483648)) begin
                saty_c = 1'b1;
                fy_c   = 32'h8000_0000;
            end else begin
                fy_c = FORCE_W'(~py + 1'b1);
            end
        end else begin
            if (py > P_W'(64'd2147483647)) begin
                saty_c = 1'b1;
                fy_c   = 32'h7FFF_FFFF;
            end else begin
                fy_c = py[FORCE_W-1:0];
            end
        end
    end

    // Coincident centres force a zero result; the dividers saw a zero divisor.
    always_ff @(posedge aclk) begin
        if (en) begin
            fx_reg   <= coind_reg ? '0 : fx_c;
            fy_reg   <= coind_reg ? '0 : fy_c;
            sat_reg  <= !coind_reg && (satx_c || saty_c);
            coin_reg <= coind_reg;
            near_reg <= neard_reg;
        end
    end

    assign m_tdata = {fy_reg, fx_reg};
    assign m_tuser = {sat_reg, coin_reg, near_reg};

    `PCC_ASSERT_IMP(a_coin_zero, aclk, aresetn, m_tvalid && coin_reg,
        fx_reg == '0 && fy_reg == '0 && !sat_reg)
    `PCC_ASSERT_IMP(a_coin_near, aclk, aresetn, m_tvalid && coin_reg, near_reg)
    `PCC_ASSERT_IMP(a_sat_extreme, aclk, aresetn, m_tvalid && sat_reg,
        fx_reg == 32'h8000_0000 || fx_reg == 32'h7FFF_FFFF ||
        fy_reg == 32'h8000_0000 || fy_reg == 32'h7FFF_FFFF)
    `PCC_ASSERT_NXT(a_stall_hold, aclk, aresetn, !en, $stable(valid_reg))
    `PCC_ASSERT_NXT(a_accept_enter, aclk, aresetn, s_tvalid && s_tready, valid_reg[0])
endmodule

// ===== tb/sv/pair_contact_coulomb_force_tb.sv =====
// Self-checking testbench for the pairwise contact and Coulomb force pipeline.
module pair_contact_coulomb_force_tb;
    import pcc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Byte addresses of the two registers on the APB port.
    localparam logic [2:0] ADDR_STRENGTH = 3'd0;
    localparam logic [2:0] ADDR_GAIN     = 3'd4;
    // Drain wait, longer than the register stages of the block pipeline.
    localparam int DRAIN_CYCLES = 120;

    typedef struct packed {
        logic signed [POS_W-1:0] ax;
        logic signed [POS_W-1:0] ay;
        logic [RAD_W-1:0]        ar;
        logic signed [POS_W-1:0] bx;
        logic signed [POS_W-1:0] by;
        logic [RAD_W-1:0]        br;
    } pair_t;

    typedef struct packed {
        logic signed [FORCE_W-1:0] fx;
        logic signed [FORCE_W-1:0] fy;
        logic                      near_hit;
        logic                      coincident;
        logic                      saturated;
    } force_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic [2:0]   m_tuser;
    logic         psel     = 1'b0;
    logic         penable  = 1'b0;
    logic         pwrite   = 1'b0;
    logic [2:0]   paddr    = '0;
    logic [31:0]  pwdata   = '0;
    logic [31:0]  prdata;
    logic         pready;

    // The predictor keeps its own copy of the two registers.
    logic [CFG_W-1:0]        model_strength = STRENGTH_RESET;
    logic signed [CFG_W-1:0] model_gain     = GAIN_RESET;

    force_t expected_forces[$];
    int     error_count   = 0;
    int     pairs_sent    = 0;
    int     forces_seen   = 0;
    int     clipped_seen  = 0;
    int     contact_seen  = 0;
    // Receiver controls: a counted hold-off and a switch for stretches with no idling.
    int     sink_hold     = 0;
    int     sink_gap      = 0;
    bit     no_idle       = 1'b0;

    pair_contact_coulomb_force dut (.*);

    always #5 aclk = ~aclk;

    // Generous fixed limit on the whole run.
    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    // Integer square root by the digit-by-digit method.
    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res = 0;
        longint unsigned b1 = 64'd1 << 62;
        while (b1 > n) b1 >>= 2;
        while (b1 != 0) begin
            if (n >= res + b1) begin
                n -= res + b1;
                res = (res >> 1) + b1;
            end else begin
                res >>= 1;
            end
            b1 >>= 2;
        end
        return res;
    endfunction

    // Projects the signed force size onto one unit component and clips it.
    function automatic longint project_clip(longint unsigned tm, bit tneg, longint u,
                                            inout bit sat);
        longint unsigned um = (u < 0) ? longint'(-u) : u;
        longint unsigned p = (tm * um) >> 14;
        bit neg = tneg != (u < 0);
        if (p == 0) return 0;
        if (neg) begin
            if (p > 64'd2147483648) begin
                sat = 1'b1;
                return -64'sd2147483648;
            end
            return -longint'(p);
        end
        if (p > 64'd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        return longint'(p);
    endfunction

    function automatic force_t predict_force(pair_t p);
        longint dx = longint'(p.ax) - longint'(p.bx);
        longint dy = longint'(p.ay) - longint'(p.by);
        longint unsigned ra = p.ar;
        longint unsigned rb = p.br;
        longint unsigned rsum = ra + rb;
        longint unsigned adx = (dx < 0) ? longint'(-dx) : dx;
        longint unsigned ady = (dy < 0) ? longint'(-dy) : dy;
        longint unsigned dist2, sep, cm, rs15, gmag, tm;
        longint ux, uy, cc, t, gain;
        bit sat = 1'b0;
        force_t f;
        f = '0;
        f.near_hit = (adx <= rsum) && (ady <= rsum);
        f.coincident = (dx == 0) && (dy == 0);
        if (!f.coincident) begin
            dist2 = adx * adx + ady * ady;
            sep = int_sqrt(dist2 << 14);
            ux = longint'((adx << 21) / sep);
            uy = longint'((ady << 21) / sep);
            gain = longint'(model_gain);
            gmag = (gain < 0) ? longint'(-gain) : gain;
            cm = (gmag * ra * rb * 2) / dist2;
            rs15 = rsum << 7;
            cc = 0;
            if (dx < 0) ux = -ux;
            if (dy < 0) uy = -uy;
            // Contact acts only inside the box and with positive overlap.
            if (f.near_hit && rs15 > sep)
                cc = longint'((longint'(model_strength) * (rs15 - sep)) >> 15);
            t = (gain < 0) ? cc - longint'(cm) : cc + longint'(cm);
            tm = (t < 0) ? longint'(-t) : t;
            f.fx = FORCE_W'(project_clip(tm, t < 0, ux, sat));
            f.fy = FORCE_W'(project_clip(tm, t < 0, uy, sat));
            f.saturated = sat;
        end
        return f;
    endfunction

    // Mostly short gaps, a few long ones.
    function automatic int random_gap();
        int r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: random gaps, plus a counted hold-off when a test asks for one.
    always @(posedge aclk) begin
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            m_tready <= 1'b0;
        end else if (sink_gap > 0 && !no_idle) begin
            sink_gap <= sink_gap - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            sink_gap <= random_gap();
        end
    end

    // Result checker: every accepted word is compared with the oldest prediction.
    always @(posedge aclk) begin
        force_t want;
        if (aresetn && m_tvalid && m_tready) begin
            forces_seen++;
            if (expected_forces.size() == 0) begin
                $error("unexpected result word fx=%0h fy=%0h", m_tdata[31:0], m_tdata[63:32]);
                error_count++;
            end else begin
                want = expected_forces.pop_front();
                if (m_tdata[31:0] !== want.fx) begin
                    $error("force_x expected %0d actual %0d", want.fx, $signed(m_tdata[31:0]));
                    error_count++;
                end
                if (m_tdata[63:32] !== want.fy) begin
                    $error("force_y expected %0d actual %0d", want.fy, $signed(m_tdata[63:32]));
                    error_count++;
                end
                if (m_tuser[0] !== want.near_hit) begin
                    $error("near_hit expected %0b actual %0b", want.near_hit, m_tuser[0]);
                    error_count++;
                end
                if (m_tuser[1] !== want.coincident) begin
                    $error("coincident expected %0b actual %0b", want.coincident, m_tuser[1]);
                    error_count++;
                end
                if (m_tuser[2] !== want.saturated) begin
                    $error("saturated expected %0b actual %0b", want.saturated, m_tuser[2]);
                    error_count++;
                end
            end
        end
    end

    // Sends one pair; valid stays high into the next call when there is no gap.
    task automatic send_pair(pair_t p);
        int gap;
        force_t f;
        s_tvalid <= 1'b1;
        s_tdata <= {p.br, p.by, p.bx, p.ar, p.ay, p.ax};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        f = predict_force(p);
        expected_forces = {expected_forces, f};
        pairs_sent++;
        if (f.saturated) clipped_seen++;
        if (f.near_hit && !f.coincident) contact_seen++;
        gap = random_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // Waits until every predicted word has arrived and the pipeline is empty.
    task automatic wait_drained();
        stop_sending();
        while (expected_forces.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_STRENGTH) model_strength = data[CFG_W-1:0];
        else if (addr == ADDR_GAIN) model_gain = data[CFG_W-1:0];
        @(posedge aclk);
    endtask

    function automatic pair_t make_pair(int ax, int ay, int ar, int bx, int by, int br);
        pair_t p;
        p.ax = POS_W'(ax); p.ay = POS_W'(ay); p.ar = RAD_W'(ar);
        p.bx = POS_W'(bx); p.by = POS_W'(by); p.br = RAD_W'(br);
        return p;
    endfunction

    // A close pair with random content, so that contact and clipping are reached.
    function automatic pair_t random_near_pair();
        pair_t p;
        int span;
        p.ar = RAD_W'($urandom);
        p.br = RAD_W'($urandom);
        if ($urandom_range(0, 3) == 0) begin
            p.ar = RAD_W'($urandom_range(0, 2047));
            p.br = RAD_W'($urandom_range(0, 2047));
        end
        span = int'(p.ar) + int'(p.br) + 16;
        p.ax = POS_W'($urandom);
        p.ay = POS_W'($urandom);
        p.bx = POS_W'(int'(p.ax) - int'($urandom_range(0, 2 * span)) + span);
        p.by = POS_W'(int'(p.ay) - int'($urandom_range(0, 2 * span)) + span);
        return p;
    endfunction

    function automatic pair_t random_pair();
        pair_t p;
        p = {$urandom, $urandom, $urandom, $urandom};
        return p;
    endfunction

    // Field extremes and each special case under the reset register values.
    task automatic test_directed();
        send_pair(make_pair(0, 0, 256, 0, 0, 256));               // coincident centres
        send_pair(make_pair(1000, -2000, 0, 1000, -2000, 0));     // coincident, zero radii
        send_pair(make_pair(8388607, 8388607, 65535, -8388608, -8388608, 65535));
        send_pair(make_pair(-8388608, 0, 0, 8388607, 0, 65535));
        send_pair(make_pair(0, -8388608, 65535, 0, 8388607, 0));
        send_pair(make_pair(0, 0, 256, 256, 0, 256));             // overlapping on x
        send_pair(make_pair(0, 0, 256, 0, -300, 256));            // overlapping on y
        send_pair(make_pair(0, 0, 256, 512, 0, 256));             // just touching
        send_pair(make_pair(0, 0, 256, 400, 400, 256));           // box passes, no overlap
        send_pair(make_pair(0, 0, 256, 600, 0, 256));             // box test fails
        send_pair(make_pair(0, 0, 65535, 1, 0, 65535));           // deep overlap
        send_pair(make_pair(0, 0, 65535, 1, 1, 65535));
        send_pair(make_pair(5, 7, 65535, 4, 7, 65535));
        send_pair(make_pair(-3, 2, 65535, -2, 1, 65535));
        send_pair(make_pair(100, 100, 0, 90, 110, 0));
    endtask

    // Each register at its extremes, with pairs that stress clipping and sign.
    task automatic test_register_extremes();
        logic [31:0] gains[4] = '{32'h0000_8000, 32'h0000_7FFF, 32'h0, 32'hFFFF_0001};
        logic [31:0] strengths[3] = '{32'hFFFF_FFFF, 32'h0, 32'h0000_0001};
        for (int g = 0; g < 4; g++) begin
            wait_drained();
            apb_write(ADDR_GAIN, gains[g]);
            apb_write(ADDR_STRENGTH, strengths[g % 3]);
            send_pair(make_pair(0, 0, 65535, 1, 0, 65535));
            send_pair(make_pair(0, 0, 65535, -1, -1, 65535));
            send_pair(make_pair(0, 0, 256, 256, 0, 256));
            send_pair(make_pair(10, 10, 10, 10, 10, 10));
            send_pair(make_pair(8388607, 0, 65535, -8388608, 0, 65535));
            for (int i = 0; i < 10; i++) send_pair(random_near_pair());
        end
    endtask

    // Random phases under several register settings.
    task automatic test_random(int count);
        for (int phase = 0; phase < 5; phase++) begin
            wait_drained();
            apb_write(ADDR_STRENGTH, $urandom);
            apb_write(ADDR_GAIN, $urandom);
            // Alternate phases run with no idling on either side.
            no_idle = (phase % 2 == 1);
            for (int i = 0; i < count / 5; i++) begin
                if ($urandom_range(0, 99) < 75) send_pair(random_near_pair());
                else send_pair(random_pair());
            end
            no_idle = 1'b0;
        end
    endtask

    // The receiver holds off while the sender keeps offering, so the input stalls.
    task automatic test_backpressure();
        wait_drained();
        apb_write(ADDR_STRENGTH, STRENGTH_RESET);
        apb_write(ADDR_GAIN, GAIN_RESET);
        model_strength = STRENGTH_RESET;
        no_idle = 1'b1;
        @(posedge aclk);
        sink_hold = 400;
        for (int i = 0; i < 200; i++) send_pair(random_near_pair());
        no_idle = 1'b0;
        // The sender then pauses until every result has come back.
        wait_drained();
        for (int i = 0; i < 40; i++) send_pair(random_near_pair());
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_register_extremes();
        test_backpressure();
        test_random(1000);
        wait_drained();
        $display("Sent %0d pairs and checked %0d force words.", pairs_sent, forces_seen);
        $display("Covered %0d near pairs and %0d clipped results under reset, extreme %s",
                 contact_seen, clipped_seen, "and random register values.");
        if (error_count == 0 && expected_forces.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
